FILE: rtl/pau_pkg.sv
`default_nettype none
package pau_pkg;

    // Number formats
    localparam int FRAC_BITS = 16;
    localparam int W         = 24;
    localparam int DT_W      = 16;
    localparam int STR_W     = 24;
    localparam int R_W       = 16;
    localparam int CFG_IDX_W = 4;

    // Datapath widths
    localparam int DTSTR_W   = DT_W + STR_W;
    localparam int DTSTR_LO  = DTSTR_W / 2;
    localparam int D_W       = W + 1;
    localparam int SQ_W      = 2 * W;
    localparam int DIST2_W   = SQ_W + 2;
    localparam int ROOT_W    = DIST2_W / 2;
    localparam int CUBE_W    = 3 * ROOT_W;
    localparam int NUM_W     = DTSTR_W + D_W + FRAC_BITS;
    localparam int PH_W      = DTSTR_W - DTSTR_LO + D_W;
    localparam int PL_W      = DTSTR_LO + D_W;
    localparam int Q_W       = W + 1;
    localparam int PROD_W    = W + DT_W + 1;
    localparam int NL_W      = R_W + FRAC_BITS + 2;

    // Pipeline depth
    localparam int DIV_LAT   = Q_W + 1;
    localparam int N_DLY     = ROOT_W + 2;
    localparam int PIPE      = 5 + ROOT_W + 3 + DIV_LAT;

    // Divide by five: multiply by ceil(2^34 / 5)
    localparam int FIFTH_Y_W = R_W + 1 + FRAC_BITS - 15;
    localparam int FIFTH_K_W = 32;
    localparam int FIFTH_SH  = 34;
    localparam logic [FIFTH_K_W-1:0] FIFTH_K = 32'd3435973837;

    localparam longint SMAX_L = 2**(W-1) - 1;
    localparam longint SMIN_L = -(2**(W-1));

    localparam logic [Q_W-1:0] GAIN_CAP = Q_W'(1) << W;
    localparam logic [W-1:0] ONE_VAL = (FRAC_BITS >= W - 1) ?
        {1'b0, {(W-1){1'b1}}} : (W'(1) << FRAC_BITS);

    // Register reset values
    localparam logic [W-1:0]     RST_ATTR_X = 24'h008000;
    localparam logic [W-1:0]     RST_ATTR_Y = 24'h00B333;
    localparam logic [W-1:0]     RST_ATTR_Z = 24'hFE0000;
    localparam logic [W-1:0]     RST_SRC_X  = 24'h000000;
    localparam logic [W-1:0]     RST_SRC_Y  = 24'h000000;
    localparam logic [W-1:0]     RST_SRC_Z  = 24'hFD0000;
    localparam logic [DT_W-1:0]  RST_DT     = 16'd1092;
    localparam logic [STR_W-1:0] RST_STR    = 24'd327680;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ATTR_X   = 4'd0,
        REG_ATTR_Y   = 4'd1,
        REG_ATTR_Z   = 4'd2,
        REG_SRC_X    = 4'd3,
        REG_SRC_Y    = 4'd4,
        REG_SRC_Z    = 4'd5,
        REG_TIME     = 4'd6,
        REG_STRENGTH = 4'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [W-1:0]   pos_x;
        logic signed [W-1:0]   pos_y;
        logic signed [W-1:0]   pos_z;
        logic signed [W-1:0]   vel_x;
        logic signed [W-1:0]   vel_y;
        logic signed [W-1:0]   vel_z;
        logic [W-1:0]          age;
        logic [W-1:0]          life_limit;
        logic signed [R_W-1:0] rand_vy;
        logic signed [R_W-1:0] rand_vz;
        logic signed [R_W-1:0] rand_life;
    } in_item_t;

    typedef struct packed {
        logic signed [W-1:0] new_pos_x;
        logic signed [W-1:0] new_pos_y;
        logic signed [W-1:0] new_pos_z;
        logic signed [W-1:0] new_vel_x;
        logic signed [W-1:0] new_vel_y;
        logic signed [W-1:0] new_vel_z;
        logic [W-1:0]        new_age;
        logic [W-1:0]        new_life_limit;
        logic                respawned;
    } out_item_t;

    // Per-particle data riding alongside the arithmetic
    typedef struct packed {
        logic [2:0][W-1:0] pos;
        logic [2:0][W-1:0] vel;
        logic [W-1:0]      age;
        logic [W-1:0]      life;
        logic              resp;
        logic [2:0]        sgn;
    } carry_t;

    function automatic logic [W-1:0] sat24(input logic signed [63:0] v);
        logic [W-1:0] r;
        if (v > SMAX_L)
        begin
            r = {1'b0, {(W-1){1'b1}}};
        end
        else if (v < SMIN_L)
        begin
            r = {1'b1, {(W-1){1'b0}}};
        end
        else
        begin
            r = v[W-1:0];
        end
        return r;
    endfunction

    // r * 2^F / (5 * 2^15), truncated toward zero, saturated
    function automatic logic [W-1:0] fifth(input logic signed [R_W-1:0] r);
        logic [R_W:0]                       m;
        logic [R_W+FRAC_BITS:0]             x;
        logic [FIFTH_Y_W-1:0]               y;
        logic [FIFTH_Y_W+FIFTH_K_W-1:0]     p;
        logic [FIFTH_Y_W-1:0]               q;
        logic signed [63:0]                 s;
        m = (R_W+1)'(r[R_W-1] ? -$signed({r[R_W-1], r}) : $signed({r[R_W-1], r}));
        x = (R_W+FRAC_BITS+1)'(m) << FRAC_BITS;
        y = FIFTH_Y_W'(x >> 15);
        p = y * FIFTH_K;
        q = FIFTH_Y_W'(p >> FIFTH_SH);
        s = r[R_W-1] ? -64'(q) : 64'(q);
        return sat24(s);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/pau_if.sv
`default_nettype none
interface pau_in_if;
    import pau_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pau_out_if;
    import pau_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pau_cfg_if;
    import pau_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [W-1:0]         wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

FILE: rtl/pau_isqrt.sv
`default_nettype none
// Pipelined floor square root, one result bit per stage.
module pau_isqrt (
    input  logic                        clk,
    input  logic                        en,
    input  logic [pau_pkg::DIST2_W-1:0] radicand,
    output logic [pau_pkg::ROOT_W-1:0]  root
);
    import pau_pkg::*;

    localparam int RT_W = DIST2_W + 2;

    logic [DIST2_W-1:0] rem_reg  [ROOT_W];
    logic [ROOT_W-1:0]  root_reg [ROOT_W];

    for (genvar s = 0; s < ROOT_W; s++)
    begin : g_stage
        localparam int B = ROOT_W - 1 - s;
        logic [DIST2_W-1:0] rem_in;
        logic [ROOT_W-1:0]  root_in;
        logic [RT_W-1:0]    term;

        if (s == 0)
        begin : g_first
            assign rem_in  = radicand;
            assign root_in = '0;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
        end

        // (root + 2^B)^2 - root^2
        assign term = (RT_W'(root_in) << (B + 1)) | (RT_W'(1) << (2 * B));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (RT_W'(rem_in) >= term)
                begin
                    rem_reg[s]  <= DIST2_W'(RT_W'(rem_in) - term);
                    root_reg[s] <= root_in | (ROOT_W'(1) << B);
                end
                else
                begin
                    rem_reg[s]  <= rem_in;
                    root_reg[s] <= root_in;
                end
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule
`default_nettype wire

FILE: rtl/pau_div.sv
`default_nettype none
// Pipelined restoring divider, quotient capped at GAIN_CAP.
module pau_div (
    input  logic                       clk,
    input  logic                       en,
    input  logic [pau_pkg::NUM_W-1:0]  num,
    input  logic [pau_pkg::CUBE_W-1:0] den,
    output logic [pau_pkg::Q_W-1:0]    gain
);
    import pau_pkg::*;

    localparam int DV_W = CUBE_W + Q_W;

    logic [NUM_W-1:0]  rem_reg [Q_W+1];
    logic [Q_W-1:0]    q_reg   [Q_W+1];
    logic [CUBE_W-1:0] den_reg [Q_W+1];
    logic              ovf_reg [Q_W+1];

    // Stage 0: quotient too large for Q_W bits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            q_reg[0]   <= '0;
            den_reg[0] <= den;
            ovf_reg[0] <= DV_W'(num) >= (DV_W'(den) << Q_W);
        end
    end

    for (genvar j = 1; j <= Q_W; j++)
    begin : g_stage
        localparam int K = Q_W - j;
        logic [DV_W-1:0] sh;

        assign sh = DV_W'(den_reg[j-1]) << K;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[j] <= den_reg[j-1];
                ovf_reg[j] <= ovf_reg[j-1];
                if (DV_W'(rem_reg[j-1]) >= sh)
                begin
                    rem_reg[j] <= NUM_W'(DV_W'(rem_reg[j-1]) - sh);
                    q_reg[j]   <= q_reg[j-1] | (Q_W'(1) << K);
                end
                else
                begin
                    rem_reg[j] <= rem_reg[j-1];
                    q_reg[j]   <= q_reg[j-1];
                end
            end
        end
    end

    assign gain = (ovf_reg[Q_W] || (q_reg[Q_W] > GAIN_CAP)) ? GAIN_CAP : q_reg[Q_W];

endmodule
`default_nettype wire

FILE: rtl/particle_attractor_update.sv
`default_nettype none
// Particle update with an inverse-square attractor. Each request on part_in
// is one particle; one result leaves on part_out per request, in order. The
// block is a fully pipelined datapath that takes one particle every clock
// cycle while part_out is not stalled. Values carry 16 fractional bits. The
// pipeline depth is set by the integer square root of |d|^2 (one bit per
// stage) followed by the division by dist^3 (one quotient bit per stage).
// A stall on part_out freezes the whole pipeline; nothing is dropped or
// repeated. The configuration port is always ready; write it only while
// the pipeline is empty.
module particle_attractor_update (
    input  logic      clk,
    input  logic      rst_n,
    pau_cfg_if.sink   cfg,
    pau_in_if.sink    part_in,
    pau_out_if.source part_out
);
    import pau_pkg::*;

    // Configuration
    logic [W-1:0]       attr_reg [3];
    logic [W-1:0]       src_reg  [3];
    logic [DT_W-1:0]    dt_reg;
    logic [STR_W-1:0]   str_reg;
    logic [DTSTR_W-1:0] dtstr_reg;

    // Pipeline control
    logic   adv;
    logic   valid_reg [1:PIPE];
    carry_t carry_reg [1:PIPE];
    carry_t carry_next[1:PIPE];

    // Stage 1
    in_item_t     di;
    logic [W:0]   age_sum;
    logic [W-1:0] age_sat;
    logic         resp1;
    logic [R_W-1:0]  u;
    logic [NL_W-1:0] nl_wide;
    logic [W-1:0]    nl;
    logic signed [PROD_W-1:0] prod_next [3];
    logic signed [PROD_W-1:0] prod_reg  [3];

    // Stages 3..6
    logic signed [D_W-1:0]   d_next [3];
    logic signed [D_W-1:0]   d_reg  [3];
    logic signed [2*D_W-1:0] sq_full[3];
    logic [SQ_W-1:0]         sq_reg [3];
    logic [D_W-1:0]          mag_reg[3];
    logic [DIST2_W-1:0]      dist2_reg;
    logic [PH_W-1:0]         ph_next[3];
    logic [PH_W-1:0]         ph_reg [3];
    logic [PL_W-1:0]         pl_next[3];
    logic [PL_W-1:0]         pl_reg [3];
    logic [NUM_W-1:0]        nd_reg [0:N_DLY][3];

    // Distance cube
    logic [ROOT_W-1:0]   root;
    logic [ROOT_W-1:0]   dist_c;
    logic [ROOT_W-1:0]   dist_reg;
    logic [DIST2_W-1:0]  dsq_reg;
    logic [DIST2_W-1:0]  pa_reg;
    logic [DIST2_W-1:0]  pb_reg;
    logic [CUBE_W-1:0]   cube_reg;
    logic [Q_W-1:0]      gain[3];

    // Output
    logic               out_valid_reg;
    out_item_t          out_reg;
    logic [W-1:0]       vel_fin[3];
    logic signed [63:0] vsum[3];

    // Whole pipeline moves unless the output holds an unaccepted result
    assign adv           = !out_valid_reg || part_out.ready;
    assign part_in.ready = adv;
    assign cfg.ready     = 1'b1;
    assign part_out.valid = out_valid_reg;
    assign part_out.data  = out_reg;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg[0] <= RST_ATTR_X;
            attr_reg[1] <= RST_ATTR_Y;
            attr_reg[2] <= RST_ATTR_Z;
            src_reg[0]  <= RST_SRC_X;
            src_reg[1]  <= RST_SRC_Y;
            src_reg[2]  <= RST_SRC_Z;
            dt_reg      <= RST_DT;
            str_reg     <= RST_STR;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_ATTR_X:   attr_reg[0] <= cfg.wdata;
                REG_ATTR_Y:   attr_reg[1] <= cfg.wdata;
                REG_ATTR_Z:   attr_reg[2] <= cfg.wdata;
                REG_SRC_X:    src_reg[0]  <= cfg.wdata;
                REG_SRC_Y:    src_reg[1]  <= cfg.wdata;
                REG_SRC_Z:    src_reg[2]  <= cfg.wdata;
                REG_TIME:     dt_reg      <= cfg.wdata[DT_W-1:0];
                REG_STRENGTH: str_reg     <= cfg.wdata;
                default:      ;
            endcase
        end
    end

    // dt * strength only changes with configuration
    always_ff @(posedge clk)
    begin
        dtstr_reg <= dt_reg * str_reg;
    end

    // Stage 1: age, respawn decision, respawn values, vel * dt
    assign di = part_in.data;

    always_comb
    begin
        age_sum = {1'b0, di.age} + (W+1)'(dt_reg);
        age_sat = age_sum[W] ? {W{1'b1}} : age_sum[W-1:0];
        resp1   = age_sat > di.life_limit;

        // new lifespan 0.5 + 2 * (rand_life mapped to [0,1))
        u       = {~di.rand_life[R_W-1], di.rand_life[R_W-2:0]};
        nl_wide = (NL_W'(1) << (FRAC_BITS - 1)) + ((NL_W'(u) << (FRAC_BITS + 1)) >> R_W);
        nl      = (nl_wide > NL_W'({W{1'b1}})) ? {W{1'b1}} : nl_wide[W-1:0];

        prod_next[0] = $signed(di.vel_x) * $signed({1'b0, dt_reg});
        prod_next[1] = $signed(di.vel_y) * $signed({1'b0, dt_reg});
        prod_next[2] = $signed(di.vel_z) * $signed({1'b0, dt_reg});
    end

    // Side-band data per stage
    always_comb
    begin
        carry_next[1].resp = resp1;
        carry_next[1].sgn  = '0;
        if (resp1)
        begin
            carry_next[1].pos[0] = src_reg[0];
            carry_next[1].pos[1] = src_reg[1];
            carry_next[1].pos[2] = src_reg[2];
            carry_next[1].vel[0] = ONE_VAL;
            carry_next[1].vel[1] = fifth(di.rand_vy);
            carry_next[1].vel[2] = fifth(di.rand_vz);
            carry_next[1].age    = '0;
            carry_next[1].life   = nl;
        end
        else
        begin
            carry_next[1].pos[0] = di.pos_x;
            carry_next[1].pos[1] = di.pos_y;
            carry_next[1].pos[2] = di.pos_z;
            carry_next[1].vel[0] = di.vel_x;
            carry_next[1].vel[1] = di.vel_y;
            carry_next[1].vel[2] = di.vel_z;
            carry_next[1].age    = age_sat;
            carry_next[1].life   = di.life_limit;
        end

        for (int k = 2; k <= PIPE; k++)
        begin
            carry_next[k] = carry_reg[k-1];
        end

        for (int i = 0; i < 3; i++)
        begin
            // Stage 2: Euler position step (floor of vel*dt), saturated
            if (!carry_reg[1].resp)
            begin
                carry_next[2].pos[i] = sat24(64'(prod_reg[i] >>> FRAC_BITS)
                                             + 64'($signed(carry_reg[1].pos[i])));
            end
            // Stage 3: d = attractor - position
            d_next[i] = D_W'($signed(attr_reg[i])) - D_W'($signed(carry_reg[2].pos[i]));
            carry_next[3].sgn[i] = d_next[i][D_W-1];
        end
    end

    // Stage 4/5 products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_full[i] = d_reg[i] * d_reg[i];
            ph_next[i] = dtstr_reg[DTSTR_W-1:DTSTR_LO] * mag_reg[i];
            pl_next[i] = dtstr_reg[DTSTR_LO-1:0] * mag_reg[i];
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= PIPE; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg[1] <= part_in.valid;
            for (int k = 2; k <= PIPE; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
            out_valid_reg <= valid_reg[PIPE];
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 1; k <= PIPE; k++)
            begin
                carry_reg[k] <= carry_next[k];
            end
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= prod_next[i];
                d_reg[i]    <= d_next[i];
                sq_reg[i]   <= sq_full[i][SQ_W-1:0];
                mag_reg[i]  <= d_reg[i][D_W-1] ? D_W'(-d_reg[i]) : D_W'(d_reg[i]);
                ph_reg[i]   <= ph_next[i];
                pl_reg[i]   <= pl_next[i];
                // numerator dt * strength * |d| * 2^F
                nd_reg[0][i] <= ((NUM_W'(ph_reg[i]) << DTSTR_LO) + NUM_W'(pl_reg[i]))
                                << FRAC_BITS;
                for (int k = 1; k <= N_DLY; k++)
                begin
                    nd_reg[k][i] <= nd_reg[k-1][i];
                end
            end
            dist2_reg <= DIST2_W'(sq_reg[0]) + DIST2_W'(sq_reg[1]) + DIST2_W'(sq_reg[2]);

            // dist^3 in three steps: clamp and square, split product, sum
            dist_reg <= dist_c;
            dsq_reg  <= dist_c * dist_c;
            pa_reg   <= dsq_reg[DIST2_W-1:ROOT_W] * dist_reg;
            pb_reg   <= dsq_reg[ROOT_W-1:0] * dist_reg;
            cube_reg <= (CUBE_W'(pa_reg) << ROOT_W) + CUBE_W'(pb_reg);

            out_reg.new_pos_x      <= carry_reg[PIPE].pos[0];
            out_reg.new_pos_y      <= carry_reg[PIPE].pos[1];
            out_reg.new_pos_z      <= carry_reg[PIPE].pos[2];
            out_reg.new_vel_x      <= vel_fin[0];
            out_reg.new_vel_y      <= vel_fin[1];
            out_reg.new_vel_z      <= vel_fin[2];
            out_reg.new_age        <= carry_reg[PIPE].age;
            out_reg.new_life_limit <= carry_reg[PIPE].life;
            out_reg.respawned      <= carry_reg[PIPE].resp;
        end
    end

    pau_isqrt u_isqrt (
        .clk      (clk),
        .en       (adv),
        .radicand (dist2_reg),
        .root     (root)
    );

    // zero distance counts as one LSB
    assign dist_c = (root == '0) ? ROOT_W'(1) : root;

    for (genvar i = 0; i < 3; i++)
    begin : g_axis
        pau_div u_div (
            .clk  (clk),
            .en   (adv),
            .num  (nd_reg[N_DLY][i]),
            .den  (cube_reg),
            .gain (gain[i])
        );
    end

    // Final: apply signed gain to velocity, keep respawn velocity as is
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            vsum[i] = 64'($signed(carry_reg[PIPE].vel[i]))
                      + (carry_reg[PIPE].sgn[i] ? -64'(gain[i]) : 64'(gain[i]));
            vel_fin[i] = carry_reg[PIPE].resp ? carry_reg[PIPE].vel[i] : sat24(vsum[i]);
        end
    end

endmodule
`default_nettype wire
